FILE: hdl/eipa_pkg.sv
// Shared constants and types for the external interrupt priority arbiter.
package eipa_pkg;

    localparam int CPU_COUNT_DEFAULT = 8;
    localparam int CPU_ADDR_W        = 3;
    localparam int MODE_W            = 3;
    localparam int SRC_W             = 3;
    localparam int PARAM_W           = 32;
    localparam int TIME_W            = 64;
    localparam int EN_W              = 8;
    localparam int S_TDATA_W         = 336;
    localparam int M_TDATA_W         = 40;
    localparam int PADDR_W           = 3;
    localparam int PDATA_W           = 32;

    localparam logic [PARAM_W-1:0] PAGE_MASK        = 32'hFFFF_F000;
    localparam logic [PARAM_W-1:0] SVC_MASK_RESET   = 32'hFFFF_FFF8;

    // Register word index, taken from paddr bit 2 upward.
    localparam logic REG_SVC_MASK = 1'b0;

    localparam logic [MODE_W-1:0] MODE_MALFUNCTION = 3'd0;
    localparam logic [MODE_W-1:0] MODE_EMERGENCY   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CALL        = 3'd2;
    localparam logic [MODE_W-1:0] MODE_KEY         = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INTERVAL    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SERVICE     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_TAKE        = 3'd6;

    localparam logic [SRC_W-1:0] SRC_KEY         = 3'd0;
    localparam logic [SRC_W-1:0] SRC_MALFUNCTION = 3'd1;
    localparam logic [SRC_W-1:0] SRC_EMERGENCY   = 3'd2;
    localparam logic [SRC_W-1:0] SRC_CALL        = 3'd3;
    localparam logic [SRC_W-1:0] SRC_COMPARATOR  = 3'd4;
    localparam logic [SRC_W-1:0] SRC_TIMER       = 3'd5;
    localparam logic [SRC_W-1:0] SRC_INTERVAL    = 3'd6;
    localparam logic [SRC_W-1:0] SRC_SERVICE     = 3'd7;

    typedef struct packed {
        logic [PARAM_W-1:0]    prefix_base;
        logic                  tracing;
        logic [TIME_W-1:0]     cpu_timer;
        logic [TIME_W-1:0]     comparator;
        logic [TIME_W-1:0]     tod_offset;
        logic [TIME_W-1:0]     tod_clock;
        logic [EN_W-1:0]       enable_bits;
        logic [PARAM_W-1:0]    service_value;
        logic [CPU_ADDR_W-1:0] source_cpu;
        logic [MODE_W-1:0]     mode;
    } item_t;

    typedef struct packed {
        logic                  taken;
        logic                  still_pending;
        logic [PARAM_W-1:0]    interrupt_param;
        logic                  origin_valid;
        logic [CPU_ADDR_W-1:0] origin_cpu;
        logic [SRC_W-1:0]      source_index;
    } result_t;

    function automatic logic [PARAM_W-1:0] prefixed(input logic [PARAM_W-1:0] param,
                                                    input logic [PARAM_W-1:0] prefix);
        logic [PARAM_W-1:0] page;
        logic [PARAM_W-1:0] pfx;
        page = param & PAGE_MASK;
        pfx  = prefix & PAGE_MASK;
        if (page == '0) begin
            prefixed = param | pfx;
        end else if (page == pfx) begin
            prefixed = param & ~PAGE_MASK;
        end else begin
            prefixed = param;
        end
    endfunction

endpackage

FILE: hdl/external_interrupt_priority_arbiter.sv
// External interrupt priority arbiter: pending sources, take arbitration and register port.
//
//   channel   dir   handshake                  payload
//   s_        in    s_tvalid / s_tready        tuser mode, tdata item fields
//   m_        out   m_tvalid / m_tready        tuser taken, tdata result fields
//   apb       in    psel, penable, pwrite      service_address_mask at byte address 0
//
// One beat per cycle while m_tready stays high; each beat is held in the input register, is
// arbitrated against the pending state and lands in the result register.
// The arbitration path is one 64-bit add and compare plus an eight-way priority select.
// Reset (synchronous, aresetn low) clears all pending sources and both stage valids.
// A stall on m_tready holds the result register; the input register still takes a beat
// whenever it is empty or its contents move on in the same cycle.
module external_interrupt_priority_arbiter #(
    parameter int CPU_COUNT = eipa_pkg::CPU_COUNT_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata from bit 0: source_cpu, service_value, enable_bits, tod_clock, tod_offset,
    // comparator, cpu_timer, prefix_base, tracing, zero fill
    input  logic [eipa_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser: mode
    input  logic [eipa_pkg::MODE_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata from bit 0: source_index, origin_cpu, origin_valid, interrupt_param,
    // still_pending
    output logic [eipa_pkg::M_TDATA_W-1:0]  m_tdata,
    // tuser: taken
    output logic                            m_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [eipa_pkg::PADDR_W-1:0]    paddr,
    input  logic [eipa_pkg::PDATA_W-1:0]    pwdata,
    output logic [eipa_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    localparam int CPU_VEC = (CPU_COUNT > 8) ? 8 : CPU_COUNT;

    eipa_pkg::item_t                  in_reg;
    logic                             in_valid_reg;
    eipa_pkg::result_t                out_reg;
    eipa_pkg::result_t                out_next;
    logic                             out_valid_reg;
    logic                             advance;

    logic [eipa_pkg::PARAM_W-1:0]     svc_mask_reg;
    logic [CPU_VEC-1:0]               malf_reg, malf_next;
    logic [CPU_VEC-1:0]               emer_reg, emer_next;
    logic                             call_reg, call_next;
    logic [eipa_pkg::CPU_ADDR_W-1:0]  call_origin_reg, call_origin_next;
    logic                             key_reg, key_next;
    logic                             intv_reg, intv_next;
    logic                             svc_reg, svc_next;
    logic [eipa_pkg::PARAM_W-1:0]     svc_param_reg, svc_param_next;

    logic                             cpu_ok;
    logic [eipa_pkg::TIME_W-1:0]      tod_sum;
    logic                             cmp_due;
    logic [eipa_pkg::CPU_ADDR_W-1:0]  malf_low, emer_low;
    logic [eipa_pkg::EN_W-1:0]        en;
    logic [eipa_pkg::PARAM_W-1:0]     svc_out;
    logic                             cfg_write;

    // Handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.taken;
    assign m_tdata  = {out_reg.still_pending, out_reg.interrupt_param, out_reg.origin_valid,
                       out_reg.origin_cpu, out_reg.source_index};

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[eipa_pkg::PADDR_W-1] ==
                                                     eipa_pkg::REG_SVC_MASK);
    assign prdata    = (paddr[eipa_pkg::PADDR_W-1] == eipa_pkg::REG_SVC_MASK) ?
                       svc_mask_reg : '0;

    always_comb begin
        malf_low = '0;
        emer_low = '0;
        for (int i = CPU_VEC - 1; i >= 0; i--) begin
            if (malf_reg[i]) begin
                malf_low = eipa_pkg::CPU_ADDR_W'(i);
            end
            if (emer_reg[i]) begin
                emer_low = eipa_pkg::CPU_ADDR_W'(i);
            end
        end
    end

    assign cpu_ok  = (32'(in_reg.source_cpu) < 32'(CPU_COUNT));
    assign tod_sum = in_reg.tod_clock + in_reg.tod_offset;
    assign cmp_due = (tod_sum > in_reg.comparator) && !in_reg.tracing;
    assign en      = in_reg.enable_bits;
    assign svc_out = ((svc_param_reg & svc_mask_reg) != '0) ?
                     eipa_pkg::prefixed(svc_param_reg, in_reg.prefix_base) : svc_param_reg;

    always_comb begin
        malf_next        = malf_reg;
        emer_next        = emer_reg;
        call_next        = call_reg;
        call_origin_next = call_origin_reg;
        key_next         = key_reg;
        intv_next        = intv_reg;
        svc_next         = svc_reg;
        svc_param_next   = svc_param_reg;
        out_next         = '0;
        unique case (in_reg.mode)
            eipa_pkg::MODE_MALFUNCTION: begin
                if (cpu_ok) begin
                    malf_next = malf_reg | (CPU_VEC'(1) << in_reg.source_cpu);
                end
            end
            eipa_pkg::MODE_EMERGENCY: begin
                if (cpu_ok) begin
                    emer_next = emer_reg | (CPU_VEC'(1) << in_reg.source_cpu);
                end
            end
            eipa_pkg::MODE_CALL: begin
                if (cpu_ok && !call_reg) begin
                    call_next        = 1'b1;
                    call_origin_next = in_reg.source_cpu;
                end
            end
            eipa_pkg::MODE_KEY:      key_next  = 1'b1;
            eipa_pkg::MODE_INTERVAL: intv_next = 1'b1;
            eipa_pkg::MODE_SERVICE: begin
                svc_param_next = (svc_param_reg & ~svc_mask_reg) | in_reg.service_value;
                svc_next       = 1'b1;
            end
            eipa_pkg::MODE_TAKE: begin
                out_next.taken = 1'b1;
                if (key_reg && en[eipa_pkg::SRC_KEY]) begin
                    key_next              = 1'b0;
                    out_next.source_index = eipa_pkg::SRC_KEY;
                end else if ((malf_reg != '0) && en[eipa_pkg::SRC_MALFUNCTION]) begin
                    malf_next             = malf_reg & ~(CPU_VEC'(1) << malf_low);
                    out_next.origin_cpu   = malf_low;
                    out_next.origin_valid = 1'b1;
                    out_next.source_index = eipa_pkg::SRC_MALFUNCTION;
                end else if ((emer_reg != '0) && en[eipa_pkg::SRC_EMERGENCY]) begin
                    emer_next             = emer_reg & ~(CPU_VEC'(1) << emer_low);
                    out_next.origin_cpu   = emer_low;
                    out_next.origin_valid = 1'b1;
                    out_next.source_index = eipa_pkg::SRC_EMERGENCY;
                end else if (call_reg && en[eipa_pkg::SRC_CALL]) begin
                    call_next             = 1'b0;
                    out_next.origin_cpu   = call_origin_reg;
                    out_next.origin_valid = 1'b1;
                    out_next.source_index = eipa_pkg::SRC_CALL;
                end else if (cmp_due && en[eipa_pkg::SRC_COMPARATOR]) begin
                    out_next.source_index = eipa_pkg::SRC_COMPARATOR;
                end else if (in_reg.cpu_timer[eipa_pkg::TIME_W-1] &&
                             en[eipa_pkg::SRC_TIMER]) begin
                    out_next.source_index = eipa_pkg::SRC_TIMER;
                end else if (intv_reg && en[eipa_pkg::SRC_INTERVAL]) begin
                    intv_next             = 1'b0;
                    out_next.source_index = eipa_pkg::SRC_INTERVAL;
                end else if (svc_reg && en[eipa_pkg::SRC_SERVICE]) begin
                    out_next.interrupt_param = svc_out;
                    svc_param_next           = '0;
                    svc_next                 = 1'b0;
                    out_next.source_index    = eipa_pkg::SRC_SERVICE;
                end else begin
                    out_next.taken = 1'b0;
                end
            end
            default: ;
        endcase
        out_next.still_pending = (malf_next != '0) || (emer_next != '0) || call_next ||
                                 key_next || intv_next || svc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            svc_mask_reg    <= eipa_pkg::SVC_MASK_RESET;
            malf_reg        <= '0;
            emer_reg        <= '0;
            call_reg        <= 1'b0;
            call_origin_reg <= '0;
            key_reg         <= 1'b0;
            intv_reg        <= 1'b0;
            svc_reg         <= 1'b0;
            svc_param_reg   <= '0;
        end else begin
            if (cfg_write) begin
                svc_mask_reg <= pwdata;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg   <= 1'b1;
                malf_reg        <= malf_next;
                emer_reg        <= emer_next;
                call_reg        <= call_next;
                call_origin_reg <= call_origin_next;
                key_reg         <= key_next;
                intv_reg        <= intv_next;
                svc_reg         <= svc_next;
                svc_param_reg   <= svc_param_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg.mode          <= s_tuser;
            in_reg.source_cpu    <= s_tdata[2:0];
            in_reg.service_value <= s_tdata[34:3];
            in_reg.enable_bits   <= s_tdata[42:35];
            in_reg.tod_clock     <= s_tdata[106:43];
            in_reg.tod_offset    <= s_tdata[170:107];
            in_reg.comparator    <= s_tdata[234:171];
            in_reg.cpu_timer     <= s_tdata[298:235];
            in_reg.prefix_base   <= s_tdata[330:299];
            in_reg.tracing       <= s_tdata[331];
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

endmodule
